### rtl/lbrw_pkg.sv
`default_nettype none

package lbrw_pkg;

    localparam int MAX_COUNT = 4096;
    localparam int IDX_W     = $clog2(MAX_COUNT);
    localparam int CNT_W     = IDX_W + 1;
    localparam int SAMPLE_W  = 16;
    localparam int LIMIT_W   = 16;
    localparam int ALU_W     = 18;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;

    // Register select taken from paddr[2]
    localparam logic REG_LIMIT = 1'b0;

    typedef struct packed {
        logic [IDX_W-1:0]           idx;
        logic signed [SAMPLE_W-1:0] val;
    } entry_t;

    typedef struct packed {
        logic clear;
        logic rd_tail;
        logic rd_head;
        logic pop_tail;
        logic pop_head;
        logic push;
    } deq_cmd_t;

    function automatic logic signed [ALU_W-1:0] sext_alu(input logic [SAMPLE_W-1:0] x);
        sext_alu = {{(ALU_W-SAMPLE_W){x[SAMPLE_W-1]}}, x};
    endfunction

    function automatic logic signed [ALU_W-1:0] zext_alu(input logic [CNT_W-1:0] x);
        zext_alu = {{(ALU_W-CNT_W){1'b0}}, x};
    endfunction

endpackage

`default_nettype wire

### rtl/lbrw_alu.sv
`default_nettype none

module lbrw_alu
    import lbrw_pkg::*;
(
    input  wire logic signed [ALU_W-1:0] a,
    input  wire logic signed [ALU_W-1:0] b,
    input  wire logic signed [ALU_W-1:0] thr,
    output logic                         gt
);

    logic signed [ALU_W-1:0] diff;

    // Operands never leave the range where a - b fits in ALU_W bits
    assign diff = a - b;
    assign gt   = (diff > thr);

endmodule

`default_nettype wire

### rtl/lbrw_deque.sv
`default_nettype none

module lbrw_deque
    import lbrw_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire deq_cmd_t cmd,
    input  wire entry_t   wdata,
    output entry_t        rdata,
    output logic          empty
);

    entry_t mem [MAX_COUNT];

    logic [CNT_W-1:0] head_reg;
    logic [CNT_W-1:0] head_next;
    logic [CNT_W-1:0] tail_reg;
    logic [CNT_W-1:0] tail_next;
    logic [CNT_W-1:0] tail_dec;
    logic [IDX_W-1:0] rd_addr;
    entry_t           rdata_reg;

    assign tail_dec = tail_reg - CNT_W'(1);
    assign rd_addr  = cmd.rd_tail ? tail_dec[IDX_W-1:0] : head_reg[IDX_W-1:0];
    assign empty    = (tail_reg == head_reg);
    assign rdata    = rdata_reg;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (cmd.clear)
        begin
            head_next = '0;
            tail_next = '0;
        end
        else
        begin
            if (cmd.pop_tail)
                tail_next = tail_dec;
            if (cmd.push)
                tail_next = tail_reg + CNT_W'(1);
            if (cmd.pop_head)
                head_next = head_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
            mem[tail_reg[IDX_W-1:0]] <= wdata;
        if (cmd.rd_tail || cmd.rd_head)
            rdata_reg <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### rtl/longest_bounded_range_window_top.sv
`default_nettype none

// Longest window of one array whose max - min stays within the limit register.
// Samples arrive one transfer at a time; first starts a new array. Each sample
// gives one result: best start, end and length so far (earliest window wins
// ties), plus overflow when the array already held 4096 samples and the sample
// was dropped. The block takes one sample at a time and is stalled meanwhile.
// Each stored sample passes the max deque's read and compare states, then the min
// deque's, then the head checks, length and best-window update, and emit; the
// first sample of an array skips the tail compares, its deques being empty. Each
// tail pop and each head drop while the window start advances repeats a read and
// a compare; pops average at most two per sample. The next sample can be
// accepted in the cycle after the result is loaded. While the output register
// holds a stalled result, the next result waits and the block stays busy. Each
// deque memory has a single read port and one subtract-and-compare unit is shared.
// An overflowed sample skips to emit. No clearing pass follows reset.
module longest_bounded_range_window_top
    import lbrw_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       item_valid,
    output logic                            item_stall,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic                       first,
    output logic                            result_valid,
    input  wire logic                       result_stall,
    output logic [IDX_W-1:0]                best_start,
    output logic [IDX_W-1:0]                best_end,
    output logic [CNT_W-1:0]                best_length,
    output logic                            overflow,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ADDR_W-1:0]          paddr,
    input  wire logic [DATA_W-1:0]          pwdata,
    output logic [DATA_W-1:0]               prdata,
    output logic                            pready
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_MAX_RD   = 4'd1;
    localparam logic [3:0] S_MAX_CMP  = 4'd2;
    localparam logic [3:0] S_MIN_RD   = 4'd3;
    localparam logic [3:0] S_MIN_CMP  = 4'd4;
    localparam logic [3:0] S_HEAD_RD  = 4'd5;
    localparam logic [3:0] S_HEAD_CMP = 4'd6;
    localparam logic [3:0] S_LEN      = 4'd7;
    localparam logic [3:0] S_BEST     = 4'd8;
    localparam logic [3:0] S_EMIT     = 4'd9;

    logic [3:0]           state_reg, state_next;
    logic [SAMPLE_W-1:0]  sample_reg, sample_next;
    logic [IDX_W-1:0]     j_reg, j_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     start_reg, start_next;
    logic [CNT_W-1:0]     len_reg, len_next;
    logic [IDX_W-1:0]     best_start_reg, best_start_next;
    logic [CNT_W-1:0]     best_len_reg, best_len_next;
    logic                 ovf_reg, ovf_next;
    logic [LIMIT_W-1:0]   limit_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]     out_start_reg, out_start_next;
    logic [IDX_W-1:0]     out_end_reg, out_end_next;
    logic [CNT_W-1:0]     out_len_reg, out_len_next;
    logic                 out_ovf_reg, out_ovf_next;

    deq_cmd_t             max_cmd, min_cmd;
    entry_t               push_data;
    entry_t               max_rdata, min_rdata;
    logic                 max_empty, min_empty;

    logic signed [ALU_W-1:0] alu_a, alu_b, alu_thr;
    logic                    alu_gt;

    logic                 item_xfer;
    logic [CNT_W-1:0]     cnt_eff;
    logic                 cfg_write;

    assign item_stall = (state_reg != S_IDLE);
    assign item_xfer  = item_valid && !item_stall;
    assign cnt_eff    = first ? '0 : count_reg;

    assign push_data.idx = j_reg;
    assign push_data.val = sample_reg;

    lbrw_deque u_max_deque (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (max_cmd),
        .wdata (push_data),
        .rdata (max_rdata),
        .empty (max_empty)
    );

    lbrw_deque u_min_deque (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (min_cmd),
        .wdata (push_data),
        .rdata (min_rdata),
        .empty (min_empty)
    );

    lbrw_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .thr (alu_thr),
        .gt  (alu_gt)
    );

    // Shared compare unit operand select
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_thr = '0;
        case (state_reg)
            S_MAX_CMP:
            begin
                alu_a = sext_alu(sample_reg);
                alu_b = sext_alu(max_rdata.val);
            end
            S_MIN_CMP:
            begin
                alu_a = sext_alu(min_rdata.val);
                alu_b = sext_alu(sample_reg);
            end
            S_HEAD_CMP:
            begin
                alu_a   = sext_alu(max_rdata.val);
                alu_b   = sext_alu(min_rdata.val);
                alu_thr = {{(ALU_W-LIMIT_W){1'b0}}, limit_reg};
            end
            S_BEST:
            begin
                alu_a = zext_alu(len_reg);
                alu_b = zext_alu(best_len_reg);
            end
            default:
            begin
                alu_a   = '0;
                alu_b   = '0;
                alu_thr = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        sample_next     = sample_reg;
        j_next          = j_reg;
        count_next      = count_reg;
        start_next      = start_reg;
        len_next        = len_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        ovf_next        = ovf_reg;
        out_valid_next  = out_valid_reg && result_stall;
        out_start_next  = out_start_reg;
        out_end_next    = out_end_reg;
        out_len_next    = out_len_reg;
        out_ovf_next    = out_ovf_reg;
        max_cmd         = '0;
        min_cmd         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_xfer)
                begin
                    if (first)
                    begin
                        max_cmd.clear   = 1'b1;
                        min_cmd.clear   = 1'b1;
                        start_next      = '0;
                        best_start_next = '0;
                        best_len_next   = '0;
                    end
                    sample_next = sample;
                    if (cnt_eff[CNT_W-1])
                    begin
                        // Array full: drop the sample, repeat the best window
                        count_next = cnt_eff;
                        ovf_next   = 1'b1;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        j_next     = cnt_eff[IDX_W-1:0];
                        count_next = cnt_eff + CNT_W'(1);
                        ovf_next   = 1'b0;
                        state_next = S_MAX_RD;
                    end
                end
            end
            S_MAX_RD:
            begin
                if (max_empty)
                begin
                    max_cmd.push = 1'b1;
                    state_next   = S_MIN_RD;
                end
                else
                begin
                    max_cmd.rd_tail = 1'b1;
                    state_next      = S_MAX_CMP;
                end
            end
            S_MAX_CMP:
            begin
                if (alu_gt)
                begin
                    max_cmd.pop_tail = 1'b1;
                    state_next       = S_MAX_RD;
                end
                else
                begin
                    max_cmd.push = 1'b1;
                    state_next   = S_MIN_RD;
                end
            end
            S_MIN_RD:
            begin
                if (min_empty)
                begin
                    min_cmd.push = 1'b1;
                    state_next   = S_HEAD_RD;
                end
                else
                begin
                    min_cmd.rd_tail = 1'b1;
                    state_next      = S_MIN_CMP;
                end
            end
            S_MIN_CMP:
            begin
                if (alu_gt)
                begin
                    min_cmd.pop_tail = 1'b1;
                    state_next       = S_MIN_RD;
                end
                else
                begin
                    min_cmd.push = 1'b1;
                    state_next   = S_HEAD_RD;
                end
            end
            S_HEAD_RD:
            begin
                max_cmd.rd_head = 1'b1;
                min_cmd.rd_head = 1'b1;
                state_next      = S_HEAD_CMP;
            end
            S_HEAD_CMP:
            begin
                if (alu_gt)
                begin
                    // Jump the start past the older head and drop that head
                    if (max_rdata.idx < min_rdata.idx)
                    begin
                        start_next       = max_rdata.idx + IDX_W'(1);
                        max_cmd.pop_head = 1'b1;
                    end
                    else
                    begin
                        start_next       = min_rdata.idx + IDX_W'(1);
                        min_cmd.pop_head = 1'b1;
                    end
                    state_next = S_HEAD_RD;
                end
                else
                begin
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                len_next   = {1'b0, j_reg} - {1'b0, start_reg} + CNT_W'(1);
                state_next = S_BEST;
            end
            S_BEST:
            begin
                if (alu_gt)
                begin
                    best_len_next   = len_reg;
                    best_start_next = start_reg;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next = 1'b1;
                    out_start_next = best_start_reg;
                    out_end_next   = best_start_reg + best_len_reg[IDX_W-1:0] - IDX_W'(1);
                    out_len_next   = best_len_reg;
                    out_ovf_next   = ovf_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            start_reg      <= '0;
            best_start_reg <= '0;
            best_len_reg   <= '0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            start_reg      <= start_next;
            best_start_reg <= best_start_next;
            best_len_reg   <= best_len_next;
            ovf_reg        <= ovf_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg    <= sample_next;
        j_reg         <= j_next;
        len_reg       <= len_next;
        out_start_reg <= out_start_next;
        out_end_reg   <= out_end_next;
        out_len_reg   <= out_len_next;
        out_ovf_reg   <= out_ovf_next;
    end

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= '0;
        else if (cfg_write)
            limit_reg <= pwdata[LIMIT_W-1:0];
    end

    assign prdata = (paddr[2] == REG_LIMIT) ? {{(DATA_W-LIMIT_W){1'b0}}, limit_reg} : '0;

    assign result_valid = out_valid_reg;
    assign best_start   = out_start_reg;
    assign best_end     = out_end_reg;
    assign best_length  = out_len_reg;
    assign overflow     = out_ovf_reg;

endmodule

`default_nettype wire
